// ===== src/lfps_pkg.sv =====
// Package with shared types and constants of the line-following PID steering block.
`default_nettype none
package lfps_pkg;
    localparam logic [2:0] CFG_IDX_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_IDX_PGAIN = 3'd1;
    localparam logic [2:0] CFG_IDX_IGAIN = 3'd2;
    localparam logic [2:0] CFG_IDX_DGAIN = 3'd3;
    localparam logic [2:0] CFG_IDX_BASE = 3'd4;
    localparam logic [2:0] CFG_IDX_UNUSED = 3'd7;

    localparam logic [3:0] DIR_STOP = 4'h0;
    localparam logic [3:0] DIR_FWD = 4'h6;
    localparam logic [3:0] DIR_BACK = 4'h9;
    localparam logic [3:0] DIR_RIGHT = 4'hA;
    localparam logic [3:0] DIR_LEFT = 4'h5;

    localparam logic [1:0] TURN_NONE = 2'd0;
    localparam logic [1:0] TURN_FWD = 2'd1;
    localparam logic [1:0] TURN_RIGHT = 2'd2;
    localparam logic [1:0] TURN_LEFT = 2'd3;

    localparam logic [1:0] PAUSE_NONE = 2'd0;
    localparam logic [1:0] PAUSE_SHORT = 2'd1;
    localparam logic [1:0] PAUSE_MID = 2'd2;
    localparam logic [1:0] PAUSE_LONG = 2'd3;

    localparam logic [7:0] DRIVE_MAX = 8'd250;
    localparam logic [7:0] DRIVE_ALL = 8'd200;
    localparam logic [7:0] DRIVE_BACK = 8'd100;
    localparam logic [7:0] DRIVE_RESET = 8'd255;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture samples, start the divider
        logic div_step;  // one restoring division step
        logic err_fix;   // form error and integral
        logic mul_p;     // proportional product
        logic mul_i;     // integral product
        logic mul_d;     // derivative product
        logic finish;    // scale, rules, result register
    } t_cmd;

    typedef struct packed {
        logic div_last;
    } t_sts;
endpackage
`default_nettype wire

// ===== src/line_follow_pid_steering.sv =====
// Top level of the line-following PID steering controller.
//
//  channel  | dir | handshake             | payload
//  s_axis   | in  | s_axis_tvalid/tready  | tdata[23:0] = left, center, right sample
//  m_axis   | out | m_axis_tvalid/tready  | tdata[37:0] = left, right, dir, pause, pid
//  cfg      | in  | i_cfg_we              | i_cfg_idx selects register, i_cfg_data value
//
// From acceptance, a beat is loaded, divided by the restoring divider, which
// produces one quotient bit a cycle, turned into error and integral, weighted
// by the gains and scaled into the result. The three gain products share one
// multiplier, taken in turn. The input is ready again once the result is
// registered, so a new beat is taken only after the last one is through.
// The result sits in an output register; a new beat is taken while that
// result still waits, but the item after it waits in its final cycle until
// the register is free. Reset is synchronous and restores the configuration
// registers, controller state, valid flag and datapath history registers.
`default_nettype none
module line_follow_pid_steering #(
    parameter int ERROR_FRAC_BITS = 12
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // left[7:0], center[15:8], right[23:16]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // left[7:0], right[15:8], dir[19:16],
                                        // pause[21:20], pid[37:22], zero fill
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [15:0] i_cfg_data
);
    import lfps_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic [7:0] r_thr, r_base;
    logic [15:0] r_kp, r_ki, r_kd;
    logic r_ovalid;
    logic [7:0] left_d, right_d;
    logic [3:0] dir_d;
    logic [1:0] pause_d;
    logic signed [15:0] pid_d;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 8'd30;
            r_kp <= 16'd30720;
            r_ki <= 16'd77;
            r_kd <= 16'd12800;
            r_base <= 8'd50;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_THRESHOLD: r_thr <= i_cfg_data[7:0];
                CFG_IDX_PGAIN: r_kp <= i_cfg_data;
                CFG_IDX_IGAIN: r_ki <= i_cfg_data;
                CFG_IDX_DGAIN: r_kd <= i_cfg_data;
                CFG_IDX_BASE: r_base <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    lfps_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_fire(s_axis_tvalid && s_axis_tready),
        .i_out_busy(r_ovalid && !m_axis_tready),
        .i_sts(sts), .o_cmd(cmd), .o_in_ready(s_axis_tready)
    );

    lfps_dp #(.FRAC(ERROR_FRAC_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_l(s_axis_tdata[7:0]), .i_c(s_axis_tdata[15:8]), .i_r(s_axis_tdata[23:16]),
        .i_thr(r_thr), .i_kp(r_kp), .i_ki(r_ki), .i_kd(r_kd), .i_base(r_base),
        .o_left(left_d), .o_right(right_d), .o_dir(dir_d), .o_pause(pause_d),
        .o_pid(pid_d)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (cmd.finish) r_ovalid <= 1'b1;
        else if (m_axis_tready) r_ovalid <= 1'b0;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {2'b0, pid_d, pause_d, dir_d, right_d, left_d};
endmodule
`default_nettype wire

// ===== src/lfps_ctrl.sv =====
// Controller state machine sequencing the datapath through one item.
`default_nettype none
module lfps_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_fire,
    input  wire                 i_out_busy,
    input  wire lfps_pkg::t_sts i_sts,
    output lfps_pkg::t_cmd      o_cmd,
    output logic                o_in_ready
);
    import lfps_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV  = 7'b0000010,
        S_ERR  = 7'b0000100,
        S_MP   = 7'b0001000,
        S_MI   = 7'b0010000,
        S_MD   = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_fire) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_ERR;
            end
            S_ERR: begin
                o_cmd.err_fix = 1'b1;
                n_state = S_MP;
            end
            S_MP: begin
                o_cmd.mul_p = 1'b1;
                n_state = S_MI;
            end
            S_MI: begin
                o_cmd.mul_i = 1'b1;
                n_state = S_MD;
            end
            S_MD: begin
                o_cmd.mul_d = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!i_out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end
endmodule
`default_nettype wire

// ===== src/lfps_dp.sv =====
// Datapath: divider, error and integral, gain products, steering rules.
`default_nettype none
module lfps_dp #(
    parameter int FRAC = 12
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  lfps_pkg::t_cmd      i_cmd,
    output lfps_pkg::t_sts      o_sts,
    input  wire  [7:0]          i_l,
    input  wire  [7:0]          i_c,
    input  wire  [7:0]          i_r,
    input  wire  [7:0]          i_thr,
    input  wire  [15:0]         i_kp,
    input  wire  [15:0]         i_ki,
    input  wire  [15:0]         i_kd,
    input  wire  [7:0]          i_base,
    output logic [7:0]          o_left,
    output logic [7:0]          o_right,
    output logic [3:0]          o_dir,
    output logic [1:0]          o_pause,
    output logic signed [15:0]  o_pid
);
    import lfps_pkg::*;

    // Weighted sum is at most 6*255, so the shifted dividend has 11+FRAC bits.
    localparam int NB = 11 + FRAC;
    localparam int CW = $clog2(NB + 1);
    localparam int KINT = ((19 * (1 << FRAC)) + 5) / 10;
    localparam int AW = 56;
    localparam int SH = FRAC + 8;

    logic [7:0] r_l, r_c, r_r;
    logic [9:0] r_den;
    logic [NB-1:0] r_quo;
    logic [10:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic signed [15:0] r_prev, r_err;
    logic signed [31:0] r_integ;
    logic signed [AW-1:0] r_acc;
    logic [1:0] r_turn;
    logic [7:0] r_hl, r_hr;
    logic [3:0] r_hd;

    logic [11:0] trial_rem;
    logic [11:0] trial_sub;
    logic [NB-1:0] dividend;
    logic [10:0] wsum;
    logic signed [NB+1:0] q_ext;
    logic signed [16:0] err_c;
    logic signed [32:0] integ_sum;
    logic signed [31:0] integ_c;
    logic signed [16:0] diff;
    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [49:0] prod;
    logic signed [AW-1:0] mag, shq;
    logic signed [AW-1:0] corr_w;
    logic signed [15:0] corr;
    logic signed [17:0] plus_v, minus_v;
    logic [7:0] d_plus, d_minus;
    logic l_hi, c_hi, r_hi, l_lo, c_lo, r_lo;
    logic [7:0] n_hl, n_hr;
    logic [3:0] n_hd;
    logic [1:0] n_turn, n_pause;

    assign wsum = {3'b0, r_l} + {2'b0, r_c, 1'b0} + {2'b0, r_r, 1'b0} + {3'b0, r_r};
    assign dividend = {wsum, {FRAC{1'b0}}};
    // Restoring division: bring down the next dividend bit (MSB first).
    assign trial_rem = {r_rem, dividend[NB-1-r_cnt]};
    assign trial_sub = trial_rem - {2'b0, r_den};
    assign o_sts.div_last = (r_cnt == CW'(NB - 1));

    assign q_ext = $signed({2'b0, r_quo}) - (NB+2)'(KINT);
    assign err_c = (r_den == 10'd0) ? {r_prev[15], r_prev} :
                   (q_ext > (NB+2)'(32767)) ? 17'sd32767 :
                   (q_ext < -(NB+2)'(32768)) ? -17'sd32768 : 17'(q_ext);
    assign integ_sum = {r_integ[31], r_integ} + 33'(err_c);
    assign integ_c = (integ_sum > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                     (integ_sum < -33'sh0_8000_0000) ? -32'sh8000_0000 : integ_sum[31:0];
    assign diff = {r_err[15], r_err} - {r_prev[15], r_prev};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.mul_p) begin
            mul_a = 33'(r_err);
            mul_b = {1'b0, i_kp};
        end else if (i_cmd.mul_i) begin
            mul_a = 33'(r_integ);
            mul_b = {1'b0, i_ki};
        end else begin
            mul_a = 33'(diff);
            mul_b = {1'b0, i_kd};
        end
    end
    assign prod = mul_a * mul_b;

    // Truncate toward zero, then saturate.
    assign mag = r_acc[AW-1] ? -r_acc : r_acc;
    assign shq = mag >>> SH;
    assign corr_w = r_acc[AW-1] ? -shq : shq;
    assign corr = (corr_w > AW'(32767)) ? 16'sh7FFF :
                  (corr_w < -AW'(32768)) ? -16'sh8000 : corr_w[15:0];
    assign plus_v = $signed({10'b0, i_base}) + 18'(corr);
    assign minus_v = $signed({10'b0, i_base}) - 18'(corr);
    assign d_plus = plus_v < 0 ? 8'd0 : (plus_v > 18'sd250 ? DRIVE_MAX : plus_v[7:0]);
    assign d_minus = minus_v < 0 ? 8'd0 : (minus_v > 18'sd250 ? DRIVE_MAX : minus_v[7:0]);

    assign l_hi = r_l > i_thr;
    assign c_hi = r_c > i_thr;
    assign r_hi = r_r > i_thr;
    assign l_lo = r_l < i_thr;
    assign c_lo = r_c < i_thr;
    assign r_lo = r_r < i_thr;

    always_comb begin
        n_hl = r_hl;
        n_hr = r_hr;
        n_hd = r_hd;
        n_turn = r_turn;
        n_pause = PAUSE_NONE;
        if (c_hi) begin
            n_hl = DRIVE_MAX; n_hr = DRIVE_MAX; n_hd = DIR_FWD; n_turn = TURN_FWD;
        end
        if (c_lo && l_lo && r_hi) begin
            n_hl = d_plus; n_hr = d_plus; n_hd = DIR_RIGHT; n_turn = TURN_RIGHT;
            n_pause = PAUSE_SHORT;
        end
        if (c_lo && l_hi && r_lo) begin
            n_hl = d_minus; n_hr = d_minus; n_hd = DIR_LEFT; n_turn = TURN_LEFT;
            n_pause = PAUSE_SHORT;
        end
        if (c_hi && l_hi && r_hi) begin
            n_hl = DRIVE_ALL; n_hr = DRIVE_ALL; n_hd = DIR_FWD; n_pause = PAUSE_LONG;
        end
        if (c_lo && l_lo && r_lo) begin
            if (r_turn == TURN_RIGHT) begin
                n_hl = d_plus; n_hd = DIR_RIGHT;
            end else if (r_turn == TURN_LEFT) begin
                n_hl = d_minus; n_hd = DIR_LEFT;
            end else begin
                n_hl = DRIVE_BACK; n_hd = DIR_BACK;
            end
            n_hr = n_hl;
            n_pause = PAUSE_MID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_integ <= '0;
            r_turn <= TURN_NONE;
            r_hl <= DRIVE_RESET;
            r_hr <= DRIVE_RESET;
            r_hd <= DIR_STOP;
            r_cnt <= '0;
        end else begin
            if (i_cmd.load) begin
                r_l <= i_l;
                r_c <= i_c;
                r_r <= i_r;
                r_den <= {2'b0, i_l} + {2'b0, i_c} + {2'b0, i_r};
                r_rem <= '0;
                r_cnt <= '0;
            end
            if (i_cmd.div_step) begin
                if (!trial_sub[11]) begin
                    r_rem <= trial_sub[10:0];
                    r_quo <= {r_quo[NB-2:0], 1'b1};
                end else begin
                    r_rem <= trial_rem[10:0];
                    r_quo <= {r_quo[NB-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.err_fix) begin
                r_err <= err_c[15:0];
                r_integ <= integ_c;
            end
            if (i_cmd.mul_p) r_acc <= AW'(prod);
            if (i_cmd.mul_i || i_cmd.mul_d) r_acc <= r_acc + AW'(prod);
            if (i_cmd.finish) begin
                r_prev <= r_err;
                r_hl <= n_hl;
                r_hr <= n_hr;
                r_hd <= n_hd;
                r_turn <= n_turn;
                o_left <= n_hl;
                o_right <= n_hr;
                o_dir <= n_hd;
                o_pause <= n_pause;
                o_pid <= corr;
            end
        end
    end
endmodule
`default_nettype wire

// ===== src/lfps_chk.sv =====
// Port-level checker for the steering block, bound to the top level.
`default_nettype none
module lfps_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [39:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("took a beat while busy");
    a_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[21:20] != 2'd0 |-> m_axis_tdata[7:0] <= 8'd250)
        else $error("drive out of range");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:38] == 2'b0)
        else $error("pad bits set");
endmodule

bind line_follow_pid_steering lfps_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
